// ===== hdl/bts_pkg.sv =====
// shared types and constants for the bilinear texture sampler
package bts_pkg;

  typedef struct packed {
    logic        mode;
    logic [15:0] texel_index;
    logic [7:0]  load_red;
    logic [7:0]  load_green;
    logic [7:0]  load_blue;
    logic [15:0] u_coord;
    logic [15:0] v_coord;
  } bts_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } bts_out_t;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] RegWidth   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPresent = 2'd2;

  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeSample = 1'b1;

  localparam int unsigned TexelW = 24;

endpackage

// ===== hdl/bts_ram.sv =====
// generic single-port-write ram with one registered read port
module bts_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hdl/bts_lerp.sv =====
// one channel blend: (a*(one-f) + b*f) >> frac, truncated to 8 bits
module bts_lerp #(
  parameter int unsigned FracBits = 16
) (
  input  logic [7:0]          a_i,
  input  logic [7:0]          b_i,
  input  logic [FracBits-1:0] f_i,
  output logic [7:0]          y_o
);
  logic [FracBits:0]   one_m_f;
  logic [FracBits+9:0] sum;

  always_comb begin
    one_m_f = (FracBits+1)'(1) << FracBits;
    one_m_f = one_m_f - {1'b0, f_i};
    sum = (FracBits+10)'(a_i) * (FracBits+10)'(one_m_f)
        + (FracBits+10)'(b_i) * (FracBits+10)'(f_i);
    y_o = sum[FracBits +: 8];
  end
endmodule

// ===== hdl/bilinear_texture_sampler.sv =====
// bilinear texture sampler top level
// a sample result is registered in each pipeline stage and in the output register before it is on the outputs
// throughput: one item per cycle; four texel ram copies give the four reads in the same cycle
// loads with an index below MAX_TEXELS write all four copies in the cycle after their transfer; loads return no result
// reset clears configuration (width 1, height 1, no texture) and the pipeline;
// texel contents are undefined until loaded; the receiver cannot stall
module bilinear_texture_sampler #(
  parameter int unsigned MAX_TEXELS = 65536,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bts_pkg::bts_in_t              in_i,
  output logic                          out_valid_o,
  output bts_pkg::bts_out_t             out_o,
  input  logic                          cfg_we_i,
  input  logic [bts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bts_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bts_pkg::*;

  localparam int unsigned AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;

  logic [8:0] width_q, height_q;
  logic       present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 9'd1;
      height_q  <= 9'd1;
      present_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth:   width_q   <= cfg_data_i;
        RegHeight:  height_q  <= cfg_data_i;
        RegPresent: present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic acc, is_load, is_samp;
  assign acc     = start && !busy;
  assign is_load = acc && (in_i.mode == ModeLoad);
  assign is_samp = acc && (in_i.mode == ModeSample);

  // stage 1: scale coordinates
  logic [8:0]  w_eff, h_eff;
  logic [24:0] pu, pv;
  assign w_eff = (width_q == 9'd0) ? 9'd1 : width_q;
  assign h_eff = (height_q == 9'd0) ? 9'd1 : height_q;
  assign pu = 25'(w_eff) * 25'(in_i.u_coord);
  assign pv = 25'(h_eff) * 25'(in_i.v_coord);

  logic        s1_v_q, s1_blk_q;
  logic [8:0]  s1_x_q, s1_y_q, s1_w_q, s1_h_q;
  logic [15:0] s1_fx_q, s1_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else         s1_v_q <= is_samp;
  end
  always_ff @(posedge clk_i) begin
    s1_blk_q <= !present_q;
    s1_x_q   <= pu[24:16];
    s1_y_q   <= pv[24:16];
    s1_fx_q  <= pu[15:0];
    s1_fy_q  <= pv[15:0];
    s1_w_q   <= w_eff;
    s1_h_q   <= h_eff;
  end

  // stage 2: neighbour addresses
  logic [8:0]  nx, ny;
  logic [17:0] row0, row1;
  logic [18:0] a_ul, a_ur, a_dl, a_dr;
  assign nx = (s1_x_q == s1_w_q - 9'd1) ? 9'd0 : s1_x_q + 9'd1;
  assign ny = (s1_y_q == s1_h_q - 9'd1) ? 9'd0 : s1_y_q + 9'd1;
  assign row0 = 18'(s1_w_q) * 18'(s1_y_q);
  assign row1 = 18'(s1_w_q) * 18'(ny);
  assign a_ul = 19'(row0) + 19'(s1_x_q);
  assign a_ur = 19'(row0) + 19'(nx);
  assign a_dl = 19'(row1) + 19'(s1_x_q);
  assign a_dr = 19'(row1) + 19'(nx);

  logic        s2_v_q, s2_blk_q;
  logic [3:0]  s2_oor_q;
  logic [AW-1:0] s2_a_q [4];
  logic [15:0] s2_fx_q, s2_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else         s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    s2_blk_q    <= s1_blk_q;
    s2_fx_q     <= s1_fx_q;
    s2_fy_q     <= s1_fy_q;
    s2_oor_q[0] <= 64'(a_ul) >= 64'(MAX_TEXELS);
    s2_oor_q[1] <= 64'(a_ur) >= 64'(MAX_TEXELS);
    s2_oor_q[2] <= 64'(a_dl) >= 64'(MAX_TEXELS);
    s2_oor_q[3] <= 64'(a_dr) >= 64'(MAX_TEXELS);
    s2_a_q[0]   <= AW'(a_ul);
    s2_a_q[1]   <= AW'(a_ur);
    s2_a_q[2]   <= AW'(a_dl);
    s2_a_q[3]   <= AW'(a_dr);
  end

  // texel rams: four copies, one per neighbour
  logic              ld_ok;
  logic [TexelW-1:0] ld_data;
  logic [TexelW-1:0] rd [4];
  assign ld_ok   = is_load && (64'(in_i.texel_index) < 64'(MAX_TEXELS));
  assign ld_data = {in_i.load_red, in_i.load_green, in_i.load_blue};

  // register the write so a sample just ahead of a load still reads the old texel
  logic              ld_we_q;
  logic [AW-1:0]     ld_addr_q;
  logic [TexelW-1:0] ld_data_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ld_we_q <= 1'b0;
    else         ld_we_q <= ld_ok;
  end
  always_ff @(posedge clk_i) begin
    ld_addr_q <= AW'(in_i.texel_index);
    ld_data_q <= ld_data;
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    bts_ram #(.Width(TexelW), .Depth(MAX_TEXELS)) u_ram (
      .clk_i   (clk_i),
      .we_i    (ld_we_q),
      .waddr_i (ld_addr_q),
      .wdata_i (ld_data_q),
      .raddr_i (s2_a_q[k]),
      .rdata_o (rd[k])
    );
  end

  logic        s3_v_q, s3_blk_q;
  logic [3:0]  s3_oor_q;
  logic [15:0] s3_fx_q, s3_fy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else         s3_v_q <= s2_v_q;
  end
  always_ff @(posedge clk_i) begin
    s3_blk_q <= s2_blk_q;
    s3_oor_q <= s2_oor_q;
    s3_fx_q  <= s2_fx_q;
    s3_fy_q  <= s2_fy_q;
  end

  // fraction to FRAC_BITS
  logic [FRAC_BITS-1:0] fx, fy;
  always_comb begin
    if (FRAC_BITS >= 16) begin
      fx = FRAC_BITS'(s3_fx_q) << (FRAC_BITS - 16);
      fy = FRAC_BITS'(s3_fy_q) << (FRAC_BITS - 16);
    end else begin
      fx = FRAC_BITS'(s3_fx_q >> (16 - FRAC_BITS));
      fy = FRAC_BITS'(s3_fy_q >> (16 - FRAC_BITS));
    end
  end

  // stage 3: horizontal blend
  logic [TexelW-1:0] tx [4];
  logic [7:0] top [3], bot [3];
  for (genvar k = 0; k < 4; k++) begin : g_mask
    assign tx[k] = s3_oor_q[k] ? '0 : rd[k];
  end

  for (genvar c = 0; c < 3; c++) begin : g_h
    bts_lerp #(.FracBits(FRAC_BITS)) u_top (
      .a_i(tx[0][16-8*c +: 8]), .b_i(tx[1][16-8*c +: 8]), .f_i(fx), .y_o(top[c]));
    bts_lerp #(.FracBits(FRAC_BITS)) u_bot (
      .a_i(tx[2][16-8*c +: 8]), .b_i(tx[3][16-8*c +: 8]), .f_i(fx), .y_o(bot[c]));
  end

  logic                 s4_v_q, s4_blk_q;
  logic [7:0]           s4_top_q [3], s4_bot_q [3];
  logic [FRAC_BITS-1:0] s4_fy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else         s4_v_q <= s3_v_q;
  end
  always_ff @(posedge clk_i) begin
    s4_blk_q <= s3_blk_q;
    s4_fy_q  <= fy;
    s4_top_q <= top;
    s4_bot_q <= bot;
  end

  // stage 4: vertical blend
  logic [7:0] col [3];
  for (genvar c = 0; c < 3; c++) begin : g_v
    bts_lerp #(.FracBits(FRAC_BITS)) u_vert (
      .a_i(s4_top_q[c]), .b_i(s4_bot_q[c]), .f_i(s4_fy_q), .y_o(col[c]));
  end

  logic     out_v_q;
  bts_out_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else         out_v_q <= s4_v_q;
  end
  always_ff @(posedge clk_i) begin
    out_q.out_red   <= s4_blk_q ? 8'd0 : col[0];
    out_q.out_green <= s4_blk_q ? 8'd0 : col[1];
    out_q.out_blue  <= s4_blk_q ? 8'd0 : col[2];
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;
endmodule
